[rtl/core/bgs_pkg.sv]
// Package for the byte-granular stack: sizes, operation codes and the
// bank request struct. No dependencies.
package bgs_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int MAX_CHUNK   = 8;
  localparam int NUM_BANKS   = 8;
  localparam int LANE_W      = $clog2(NUM_BANKS);
  localparam int ROW_DEPTH   = STORE_BYTES / NUM_BANKS;
  localparam int ROW_W       = $clog2(ROW_DEPTH);
  localparam int LVL_W       = 11;
  localparam int LEN_W       = 4;
  localparam int DATA_W      = 64;
  localparam int OP_W        = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } bgs_op_t;

  typedef enum logic {
    ST_RUN,
    ST_PEEK
  } bgs_state_t;

  // Request to the bank array: write or read len bytes starting at base
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [LVL_W-1:0] base;
    logic [LEN_W-1:0] len;
  } bgs_bank_req_t;

endpackage

[rtl/core/bgs_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module bgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, otherwise register the read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/core/bgs_banks.sv]
// Eight-way byte-banked store: rotates push bytes onto the banks and
// aligns peeked bytes back. Depends on bgs_pkg and bgs_ram.
module bgs_banks
  import bgs_pkg::*;
(
  input  logic              clk,
  input  bgs_bank_req_t     req,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [LANE_W-1:0] lane_q;
  logic [LEN_W-1:0]  len_q;
  logic [NUM_BANKS-1:0]       bank_en;
  logic [ROW_W-1:0]           bank_addr  [NUM_BANKS];
  logic [7:0]                 bank_wdata [NUM_BANKS];
  logic [7:0]                 bank_rdata [NUM_BANKS];

  // Map each bank to its byte offset from the base and its row
  always_comb begin
    logic [LANE_W-1:0]        k;
    logic [LVL_W-LANE_W-1:0]  row;
    for (int b = 0; b < NUM_BANKS; b++) begin
      k = LANE_W'(b) - req.base[LANE_W-1:0];
      row = req.base[LVL_W-1:LANE_W]
          + ((LANE_W'(b) < req.base[LANE_W-1:0]) ? (LVL_W-LANE_W)'(1)
                                                  : (LVL_W-LANE_W)'(0));
      bank_addr[b]  = row[ROW_W-1:0];
      bank_wdata[b] = wdata[8*k +: 8];
      bank_en[b]    = req.rd || (req.wr && ({1'b0, k} < req.len));
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    bgs_ram #(
      .WIDTH(8),
      .DEPTH(ROW_DEPTH)
    ) u_ram (
      .clk  (clk),
      .en   (bank_en[g]),
      .we   (req.wr),
      .addr (bank_addr[g]),
      .wdata(bank_wdata[g]),
      .rdata(bank_rdata[g])
    );
  end

  // Hold alignment of the pending read
  always_ff @(posedge clk) begin
    if (req.rd) begin
      lane_q <= req.base[LANE_W-1:0];
      len_q  <= req.len;
    end
  end

  // Rotate bank outputs to byte order and zero unused bytes
  always_comb begin
    logic [LANE_W-1:0] src;
    for (int i = 0; i < NUM_BANKS; i++) begin
      src = lane_q + LANE_W'(i);
      rdata[8*i +: 8] = (LEN_W'(i) < len_q) ? bank_rdata[src] : 8'd0;
    end
  end

endmodule

[rtl/core/byte_granular_stack_top.sv]
// Top level of the byte-granular stack: request decode, fill level,
// capacity register and result register. Depends on bgs_pkg and bgs_banks.

// A byte-addressed LIFO. Each request pushes, pops or peeks 0 to 8 bytes and
// gives one result with status, read data, fill level, empty and full. Push
// and pop requests may follow back to back; a peek waits on the registered
// read of the eight byte banks, and in_stall is high in the ST_PEEK state it
// enters. A result waiting on out_stall holds off the next request. Write
// capacity only while no request is in flight.
module byte_granular_stack_top
  import bgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              capacity_we,
  input  logic [LVL_W-1:0]  capacity_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   req_type,
  input  logic [LEN_W-1:0]  length,
  input  logic [DATA_W-1:0] push_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [DATA_W-1:0] read_data,
  output logic [LVL_W-1:0]  level,
  output logic              empty_res,
  output logic              full_res
);

  bgs_state_t        state, state_next;
  logic [LVL_W-1:0]  capacity, fill, fill_next;
  logic [LVL_W-1:0]  eff_cap;
  logic [LVL_W:0]    push_sum;
  logic              accept, res_ok, len_ok;
  logic              out_done;
  bgs_bank_req_t     bank_req;
  logic [DATA_W-1:0] bank_rdata;

  assign accept   = in_valid && !in_stall;
  assign out_done = out_valid && !out_stall;
  assign eff_cap  = (capacity > LVL_W'(STORE_BYTES)) ? LVL_W'(STORE_BYTES) : capacity;
  assign push_sum = {1'b0, fill} + (LVL_W+1)'(length);
  assign len_ok   = length <= LEN_W'(MAX_CHUNK);

  // Decode the request, check space and steer the banks
  always_comb begin
    state_next    = state;
    in_stall      = (state == ST_PEEK) || (out_valid && out_stall);
    fill_next     = fill;
    res_ok        = 1'b0;
    bank_req.wr   = 1'b0;
    bank_req.rd   = 1'b0;
    bank_req.base = fill;
    bank_req.len  = length;
    unique case (state)
      ST_RUN: begin
        if (in_valid && !in_stall) begin
          unique case (bgs_op_t'(req_type))
            OP_PUSH: begin
              if (len_ok && push_sum <= {1'b0, eff_cap}) begin
                res_ok      = 1'b1;
                fill_next   = push_sum[LVL_W-1:0];
                bank_req.wr = 1'b1;
              end
            end
            OP_POP: begin
              if (len_ok && fill >= LVL_W'(length)) begin
                res_ok    = 1'b1;
                fill_next = fill - LVL_W'(length);
              end
            end
            OP_PEEK: begin
              res_ok        = len_ok && fill >= LVL_W'(length);
              bank_req.rd   = 1'b1;
              bank_req.base = fill - LVL_W'(length);
              bank_req.len  = res_ok ? length : '0;
              state_next    = ST_PEEK;
            end
            default: res_ok = 1'b0;
          endcase
        end
      end
      ST_PEEK: state_next = ST_RUN;
      default: state_next = ST_RUN;
    endcase
  end

  // Advance state, level, capacity and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      fill      <= '0;
      capacity  <= LVL_W'(STORE_BYTES);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (capacity_we) begin
        capacity <= capacity_data;
      end
      if (state == ST_PEEK) begin
        out_valid <= 1'b1;
      end else if (accept && bgs_op_t'(req_type) != OP_PEEK) begin
        out_valid <= 1'b1;
      end else if (out_done) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load result fields on a transfer in; peek data loads in the ST_PEEK state
  always_ff @(posedge clk) begin
    if (accept) begin
      ok        <= res_ok;
      level     <= fill_next;
      empty_res <= fill_next == '0;
      full_res  <= fill_next == eff_cap;
      read_data <= '0;
    end else if (state == ST_PEEK) begin
      read_data <= bank_rdata;
    end
  end

  bgs_banks u_banks (
    .clk  (clk),
    .req  (bank_req),
    .wdata(push_data),
    .rdata(bank_rdata)
  );

endmodule

[bench/bgs_stack_checker.sv]
// Checker for the byte-granular stack: watches both channels and the capacity
// port, predicts every result and compares it field by field.
// Depends on bgs_pkg.
module bgs_stack_checker
  import bgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              capacity_we,
  input  logic [LVL_W-1:0]  capacity_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [OP_W-1:0]   req_type,
  input  logic [LEN_W-1:0]  length,
  input  logic [DATA_W-1:0] push_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              ok,
  input  logic [DATA_W-1:0] read_data,
  input  logic [LVL_W-1:0]  level,
  input  logic              empty_res,
  input  logic              full_res,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [LVL_W-1:0]  lvl;
    logic              empty;
    logic              full;
  } stack_result_t;

  // Shadow copy of the stack contents, fill level and capacity register
  logic [7:0]    shadow_bytes [STORE_BYTES];
  int unsigned   shadow_level;
  int unsigned   shadow_cap;
  stack_result_t expected_results [$];

  // Apply one request to the shadow stack and return the result it gives
  function automatic stack_result_t stack_predict(bgs_op_t op, logic [LEN_W-1:0] len,
                                                  logic [DATA_W-1:0] data);
    stack_result_t res;
    int unsigned   cap_eff;
    int unsigned   base;
    int            i;
    res = '0;
    // a capacity beyond the store acts as the whole store
    cap_eff = (shadow_cap > STORE_BYTES) ? STORE_BYTES : shadow_cap;
    if (len <= MAX_CHUNK) begin
      case (op)
        OP_PUSH: begin
          if (shadow_level + len <= cap_eff) begin
            for (i = 0; i < len; i++)
              shadow_bytes[shadow_level + i] = data[8*i +: 8];
            shadow_level += len;
            res.ok = 1'b1;
          end
        end
        OP_POP: begin
          if (shadow_level >= len) begin
            shadow_level -= len;
            res.ok = 1'b1;
          end
        end
        OP_PEEK: begin
          if (shadow_level >= len) begin
            base = shadow_level - len;
            for (i = 0; i < len; i++)
              res.data[8*i +: 8] = shadow_bytes[base + i];
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
    end
    res.lvl   = shadow_level[LVL_W-1:0];
    res.empty = (shadow_level == 0);
    res.full  = (shadow_level == cap_eff);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare transfers out first, then queue predictions for transfers in
  always @(posedge clk) begin
    stack_result_t want;
    if (rst) begin
      expected_results.delete();
      shadow_level = 0;
      shadow_cap   = STORE_BYTES;
    end else begin
      if (capacity_we)
        shadow_cap = capacity_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: expected nothing, actual level %0d",
                   $time, level);
        end else begin
          want = expected_results.pop_front();
          check_field("ok", want.ok, ok);
          check_field("read_data", want.data, read_data);
          check_field("level", want.lvl, level);
          check_field("empty_res", want.empty, empty_res);
          check_field("full_res", want.full, full_res);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(stack_predict(bgs_op_t'(req_type), length, push_data));
    end
    pending = expected_results.size();
  end

endmodule

[bench/tb_top.sv]
// Testbench top for the byte-granular stack: clock, reset, request stimulus,
// capacity phases and the verdict. Depends on bgs_pkg, bgs_stack_checker and
// byte_granular_stack_top.
module tb_top;
  import bgs_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RUN_LIMIT  = 200000;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              capacity_we   = 1'b0;
  logic [LVL_W-1:0]  capacity_data = '0;
  logic              in_valid      = 1'b0;
  logic [OP_W-1:0]   req_type      = '0;
  logic [LEN_W-1:0]  length        = '0;
  logic [DATA_W-1:0] push_data     = '0;
  logic              out_stall     = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              ok;
  logic [DATA_W-1:0] read_data;
  logic [LVL_W-1:0]  level;
  logic              empty_res;
  logic              full_res;
  logic              traffic_gaps  = 1'b1;
  int                chk_errors;
  int                chk_pending;

  always #(CLK_PERIOD / 2) clk = ~clk;

  byte_granular_stack_top dut (
    .clk          (clk),
    .rst          (rst),
    .capacity_we  (capacity_we),
    .capacity_data(capacity_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .length       (length),
    .push_data    (push_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .read_data    (read_data),
    .level        (level),
    .empty_res    (empty_res),
    .full_res     (full_res)
  );

  bgs_stack_checker stack_chk (
    .clk          (clk),
    .rst          (rst),
    .capacity_we  (capacity_we),
    .capacity_data(capacity_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .length       (length),
    .push_data    (push_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .read_data    (read_data),
    .level        (level),
    .empty_res    (empty_res),
    .full_res     (full_res),
    .errors       (chk_errors),
    .pending      (chk_pending)
  );

  // Abort a hung run
  initial begin
    #(RUN_LIMIT * CLK_PERIOD);
    $display("FAIL byte_granular_stack_top");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up, rare short ones
  initial begin : result_side
    int hold_left;
    int cyc;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 600)
        hold_left = 150;
      else if (traffic_gaps && hold_left == 0 && $urandom_range(0, 1999) == 0)
        hold_left = $urandom_range(30, 90);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (traffic_gaps) begin
        out_stall <= ($urandom_range(0, 99) < 21);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_req(bgs_op_t op, int len, logic [DATA_W-1:0] data);
    while (traffic_gaps && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= op;
    length    <= len[LEN_W-1:0];
    push_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain the block, then write the capacity register
  task automatic set_capacity(int cap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    capacity_we   <= 1'b1;
    capacity_data <= cap[LVL_W-1:0];
    @(posedge clk);
    capacity_we   <= 1'b0;
  endtask

  // One random request; weights in percent after 3 percent idle ops, the rest are peeks
  task automatic random_req(int push_w, int pop_w);
    int      pick;
    int      len;
    bgs_op_t op;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      op = OP_NONE;
    else if (pick < 3 + push_w)
      op = OP_PUSH;
    else if (pick < 3 + push_w + pop_w)
      op = OP_POP;
    else
      op = OP_PEEK;
    len = ($urandom_range(0, 99) < 6) ? $urandom_range(MAX_CHUNK + 1, 15)
                                      : $urandom_range(0, MAX_CHUNK);
    send_req(op, len, {$urandom, $urandom});
  endtask

  task automatic run_phase(int cap, int count, int push_w, int pop_w);
    set_capacity(cap);
    repeat (count) random_req(push_w, pop_w);
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stack, extremes of data and length, refusals, idle op
    send_req(OP_PEEK, 0, '0);
    send_req(OP_POP, 0, '0);
    send_req(OP_POP, 1, '0);
    send_req(OP_PEEK, 1, '0);
    send_req(OP_PUSH, 0, '1);
    send_req(OP_PUSH, 8, '1);
    send_req(OP_PUSH, 8, '0);
    send_req(OP_PEEK, 8, '0);
    send_req(OP_PEEK, 3, '1);
    send_req(OP_POP, 3, '0);
    send_req(OP_PUSH, 9, '1);
    send_req(OP_POP, 15, '1);
    send_req(OP_PEEK, 12, '0);
    send_req(OP_NONE, 8, '1);
    send_req(OP_NONE, 0, '0);
    send_req(OP_PUSH, 1, 64'hffff_ffff_ffff_ffa5);
    send_req(OP_PUSH, 7, 64'h0123_4567_89ab_cdef);
    send_req(OP_PEEK, 8, '1);
    send_req(OP_PEEK, 6, '0);
    send_req(OP_POP, 6, '0);
    send_req(OP_PEEK, 5, '0);
    send_req(OP_POP, 8, '0);
    send_req(OP_POP, 7, '0);

    // Zero capacity, then oversize capacity filled up to the whole store
    run_phase(0, 60, 40, 30);
    run_phase(2047, 420, 75, 12);
    // Capacity below the level: pushes refused until pops bring it back
    run_phase(100, 350, 20, 60);

    // Small capacity with no idling on either side
    set_capacity(24);
    traffic_gaps <= 1'b0;
    repeat (300) random_req(45, 40);
    traffic_gaps <= 1'b1;

    run_phase(1024, 250, 50, 35);
    run_phase($urandom_range(1, 2047), 150, 45, 40);
    run_phase(8, 150, 45, 40);

    // Drain and settle before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (chk_errors == 0 && chk_pending == 0)
      $display("PASS byte_granular_stack_top");
    else
      $display("FAIL byte_granular_stack_top");
    $finish;
  end

endmodule
